// ----- rtl/rbsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rbsi_pkg: shared types and constants for the ray box slab intersect block
// Holds the coordinate widths and the record that each axis lane hands to
// the merging stage.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int AXES        = 3;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = DIFF_W + COORD_WIDTH;
  localparam int SHIFT_W     = PROD_W - FRAC_BITS;
  localparam int STAGES      = 5;

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  localparam logic signed [1:0] NORMAL_POS  = 2'sb01;
  localparam logic signed [1:0] NORMAL_NEG  = 2'sb11;
  localparam logic signed [1:0] NORMAL_NONE = 2'sb00;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] tmin;
    logic signed [COORD_WIDTH-1:0] tmax;
    logic                          recip_pos;
    logic                          recip_neg;
  } lane_t;

endpackage

// ----- rtl/ray_box_slab_intersect.sv -----
// Throughput: one request per cycle, set by the five-stage pipeline that
// advances as a whole whenever the output register is free or being taken.
// Reset: asynchronous and active low; it clears all stage valid bits, so no
// result is presented until a new request has passed through.
// ----------------------------------------------------------------------------
// ray_box_slab_intersect: ray versus axis-aligned box test in Q16.16
// Three axis lanes compute ordered slab distances; a merging stage gives
// entry and exit distances, the hit flag and the entry face normal.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [rbsi_pkg::COORD_WIDTH-1:0]  origin_x_i,
  input  logic signed [rbsi_pkg::COORD_WIDTH-1:0]  origin_y_i,
  input  logic signed [rbsi_pkg::COORD_WIDTH-1:0]  origin_z_i,
  input  logic signed [rbsi_pkg::COORD_WIDTH-1:0]  recip_x_i,
  input  logic signed [rbsi_pkg::COORD_WIDTH-1:0]  recip_y_i,
  input  logic signed [rbsi_pkg::COORD_WIDTH-1:0]  recip_z_i,
  input  logic signed [rbsi_pkg::COORD_WIDTH-1:0]  box_lo_x_i,
  input  logic signed [rbsi_pkg::COORD_WIDTH-1:0]  box_lo_y_i,
  input  logic signed [rbsi_pkg::COORD_WIDTH-1:0]  box_lo_z_i,
  input  logic signed [rbsi_pkg::COORD_WIDTH-1:0]  box_hi_x_i,
  input  logic signed [rbsi_pkg::COORD_WIDTH-1:0]  box_hi_y_i,
  input  logic signed [rbsi_pkg::COORD_WIDTH-1:0]  box_hi_z_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic                                     hit_o,
  output logic signed [rbsi_pkg::COORD_WIDTH-1:0]  near_dist_o,
  output logic signed [rbsi_pkg::COORD_WIDTH-1:0]  far_dist_o,
  output logic signed [1:0]                        normal_x_o,
  output logic signed [1:0]                        normal_y_o,
  output logic signed [1:0]                        normal_z_o
);
  import rbsi_pkg::*;

  logic                          en;
  logic [STAGES-1:0]             vld_d, vld_q;
  logic signed [COORD_WIDTH-1:0] org [AXES];
  logic signed [COORD_WIDTH-1:0] rcp [AXES];
  logic signed [COORD_WIDTH-1:0] blo [AXES];
  logic signed [COORD_WIDTH-1:0] bhi [AXES];
  lane_t [AXES-1:0]              lanes;

  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign rcp[0] = recip_x_i;
  assign rcp[1] = recip_y_i;
  assign rcp[2] = recip_z_i;
  assign blo[0] = box_lo_x_i;
  assign blo[1] = box_lo_y_i;
  assign blo[2] = box_lo_z_i;
  assign bhi[0] = box_hi_x_i;
  assign bhi[1] = box_hi_y_i;
  assign bhi[2] = box_hi_z_i;

  assign en         = !(vld_q[STAGES-1] && out_stall_i);
  assign in_stall_o = !en;
  assign vld_d      = {vld_q[STAGES-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    rbsi_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .origin_i (org[g]),
      .recip_i  (rcp[g]),
      .box_lo_i (blo[g]),
      .box_hi_i (bhi[g]),
      .res_o    (lanes[g])
    );
  end

  rbsi_merge u_merge (
    .clk_i       (clk_i),
    .en_i        (en),
    .lanes_i     (lanes),
    .hit_o       (hit_o),
    .near_dist_o (near_dist_o),
    .far_dist_o  (far_dist_o),
    .normal_x_o  (normal_x_o),
    .normal_y_o  (normal_y_o),
    .normal_z_o  (normal_z_o)
  );

  assign out_valid_o = vld_q[STAGES-1];

  a_fill_tracks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> vld_q[0] == $past(in_valid_i))
    else $error("first stage valid does not follow the accepted request");

  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while the output was blocked");

  a_hit_far_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !far_dist_o[COORD_WIDTH-1] && (far_dist_o >= near_dist_o))
    else $error("hit reported with far before near or behind the origin");

  a_single_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({normal_x_o != NORMAL_NONE, normal_y_o != NORMAL_NONE,
                              normal_z_o != NORMAL_NONE}))
    else $error("more than one axis carries a normal");

endmodule

// ----- rtl/rbsi_lane.sv -----
// ----------------------------------------------------------------------------
// rbsi_lane: slab distances for one axis
// Forms both corner offsets, multiplies them by the reciprocal direction,
// floors and saturates the products, and orders the two distances.
// ----------------------------------------------------------------------------
module rbsi_lane (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  logic signed [rbsi_pkg::COORD_WIDTH-1:0]  origin_i,
  input  logic signed [rbsi_pkg::COORD_WIDTH-1:0]  recip_i,
  input  logic signed [rbsi_pkg::COORD_WIDTH-1:0]  box_lo_i,
  input  logic signed [rbsi_pkg::COORD_WIDTH-1:0]  box_hi_i,
  output rbsi_pkg::lane_t                          res_o
);
  import rbsi_pkg::*;

  logic signed [DIFF_W-1:0]      dlo_d, dlo_q, dhi_d, dhi_q;
  logic signed [COORD_WIDTH-1:0] rcp_q;
  logic signed [PROD_W-1:0]      plo_d, plo_q, phi_d, phi_q;
  logic                          pos_q, neg_q;
  logic signed [SHIFT_W-1:0]     slo, shi;
  logic signed [COORD_WIDTH-1:0] tlo, thi;
  lane_t                         res_d, res_q;

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
    input logic signed [SHIFT_W-1:0] v
  );
    logic fits;
    fits = (v[SHIFT_W-1:COORD_WIDTH-1] == {(SHIFT_W-COORD_WIDTH+1){v[COORD_WIDTH-1]}});
    if (fits) begin
      return v[COORD_WIDTH-1:0];
    end else if (v[SHIFT_W-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

  assign dlo_d = {box_lo_i[COORD_WIDTH-1], box_lo_i} - {origin_i[COORD_WIDTH-1], origin_i};
  assign dhi_d = {box_hi_i[COORD_WIDTH-1], box_hi_i} - {origin_i[COORD_WIDTH-1], origin_i};

  assign plo_d = PROD_W'(dlo_q) * PROD_W'(rcp_q);
  assign phi_d = PROD_W'(dhi_q) * PROD_W'(rcp_q);

  // Dropping the fraction bits of a two's complement product floors it.
  assign slo = plo_q[PROD_W-1:FRAC_BITS];
  assign shi = phi_q[PROD_W-1:FRAC_BITS];
  assign tlo = sat_coord(slo);
  assign thi = sat_coord(shi);

  always_comb begin
    res_d.recip_pos = pos_q;
    res_d.recip_neg = neg_q;
    if (tlo < thi) begin
      res_d.tmin = tlo;
      res_d.tmax = thi;
    end else begin
      res_d.tmin = thi;
      res_d.tmax = tlo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dlo_q <= dlo_d;
      dhi_q <= dhi_d;
      rcp_q <= recip_i;
      plo_q <= plo_d;
      phi_q <= phi_d;
      pos_q <= (rcp_q > 0);
      neg_q <= (rcp_q < 0);
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/rbsi_merge.sv -----
// ----------------------------------------------------------------------------
// rbsi_merge: combines the three axis lanes
// Picks the entry axis and its normal, takes near and far, and decides hit.
// ----------------------------------------------------------------------------
module rbsi_merge (
  input  logic                                            clk_i,
  input  logic                                            en_i,
  input  rbsi_pkg::lane_t [rbsi_pkg::AXES-1:0]            lanes_i,
  output logic                                            hit_o,
  output logic signed [rbsi_pkg::COORD_WIDTH-1:0]         near_dist_o,
  output logic signed [rbsi_pkg::COORD_WIDTH-1:0]         far_dist_o,
  output logic signed [1:0]                               normal_x_o,
  output logic signed [1:0]                               normal_y_o,
  output logic signed [1:0]                               normal_z_o
);
  import rbsi_pkg::*;

  logic                          gt01, gt02, gt12;
  logic [AXES-1:0]               sel;
  logic signed [COORD_WIDTH-1:0] near_d, near_q, far_d, far_q, far01, near0;
  logic signed [1:0]             nrm_d [AXES];
  logic signed [1:0]             nrm_q [AXES];
  logic signed [1:0]             nrm_out_q [AXES];
  logic signed [COORD_WIDTH-1:0] near_out_q, far_out_q;
  logic                          hit_d, hit_q;

  assign gt01 = lanes_i[0].tmin > lanes_i[1].tmin;
  assign gt02 = lanes_i[0].tmin > lanes_i[2].tmin;
  assign gt12 = lanes_i[1].tmin > lanes_i[2].tmin;

  // Ties resolve toward the later axis.
  assign sel[0] = gt01 && gt02;
  assign sel[1] = !gt01 && gt12;
  assign sel[2] = !sel[0] && !sel[1];

  always_comb begin
    near_d = lanes_i[2].tmin;
    if (sel[0]) begin
      near_d = lanes_i[0].tmin;
    end else if (sel[1]) begin
      near_d = lanes_i[1].tmin;
    end
    far01 = (lanes_i[1].tmax < lanes_i[0].tmax) ? lanes_i[1].tmax : lanes_i[0].tmax;
    far_d = (lanes_i[2].tmax < far01) ? lanes_i[2].tmax : far01;
    for (int k = 0; k < AXES; k++) begin
      nrm_d[k] = NORMAL_NONE;
      if (sel[k] && lanes_i[k].recip_pos) begin
        nrm_d[k] = NORMAL_NEG;
      end else if (sel[k] && lanes_i[k].recip_neg) begin
        nrm_d[k] = NORMAL_POS;
      end
    end
  end

  assign near0 = near_q[COORD_WIDTH-1] ? '0 : near_q;
  assign hit_d = (far_q >= near0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      near_q     <= near_d;
      far_q      <= far_d;
      nrm_q      <= nrm_d;
      near_out_q <= near_q;
      far_out_q  <= far_q;
      nrm_out_q  <= nrm_q;
      hit_q      <= hit_d;
    end
  end

  assign hit_o       = hit_q;
  assign near_dist_o = near_out_q;
  assign far_dist_o  = far_out_q;
  assign normal_x_o  = nrm_out_q[0];
  assign normal_y_o  = nrm_out_q[1];
  assign normal_z_o  = nrm_out_q[2];

endmodule
